// ===== hw/rtl/cobb_pkg.sv =====
// ----------------------------------------------------------------------------
// cobb_pkg: shared types and constants for the closest point on oriented box
// Field layout of the box registers, fixed arithmetic widths and the
// register index codes of the configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cobb_pkg;

    // Register field layout: three 16-bit fields, x in the low bits
    localparam int FIELD_BITS      = 16;
    localparam int CFG_WIDTH       = 48;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int DIM             = 3;
    localparam int AXIS_COUNT      = 3;

    // Fixed point: coordinates Q8.8, axes Q2.14
    localparam int AXIS_FRAC   = 14;
    // Clamped distance: extent (16 bits) scaled by 2^14, plus sign
    localparam int DIST_W      = FIELD_BITS + AXIS_FRAC + 1;
    // Accumulator with 36 fraction bits; bounded by 3 * 2^45 + 2^43
    localparam int ACC_W       = 48;
    // Shift from 36 to 8 fraction bits
    localparam int ROUND_SHIFT = 28;

    // Register stages per cell and total latency from transfer to result
    localparam int CELL_STAGES = 3;
    localparam int LATENCY     = 2 + CELL_STAGES * AXIS_COUNT;

    // Register reset values
    localparam logic [CFG_WIDTH-1:0] BOX_CENTER_RESET   = 48'h0000_0000_0000;
    localparam logic [CFG_WIDTH-1:0] AXIS_FIRST_RESET   = 48'h0000_0000_4000;
    localparam logic [CFG_WIDTH-1:0] AXIS_SECOND_RESET  = 48'h0000_4000_0000;
    localparam logic [CFG_WIDTH-1:0] AXIS_THIRD_RESET   = 48'h4000_0000_0000;
    localparam logic [CFG_WIDTH-1:0] HALF_EXTENTS_RESET = 48'h0000_0000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_BOX_CENTER   = 3'd0,
        REG_AXIS_FIRST   = 3'd1,
        REG_AXIS_SECOND  = 3'd2,
        REG_AXIS_THIRD   = 3'd3,
        REG_HALF_EXTENTS = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cobb_cell.sv =====
// ----------------------------------------------------------------------------
// cobb_cell: one axis of the box
// Projects the offset onto its axis, clamps the distance to the half extent
// and adds the scaled axis to the running sum, handing both on each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobb_cell #(
    parameter int DW = 17
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic signed [DW-1:0]                       d_in [cobb_pkg::DIM],
    input  logic signed [cobb_pkg::ACC_W-1:0]          acc_in [cobb_pkg::DIM],
    input  logic        [cobb_pkg::CFG_WIDTH-1:0]      axis,
    input  logic        [cobb_pkg::FIELD_BITS-1:0]     extent,
    output logic                                       out_valid,
    output logic signed [DW-1:0]                       d_out [cobb_pkg::DIM],
    output logic signed [cobb_pkg::ACC_W-1:0]          acc_out [cobb_pkg::DIM]
);

    import cobb_pkg::*;

    localparam int PW    = DW + FIELD_BITS;
    localparam int DOT_W = PW + 2;

    logic signed [FIELD_BITS-1:0] u [DIM];

    logic signed [PW-1:0]     prod_next [DIM];
    logic signed [PW-1:0]     prod_reg  [DIM];
    logic signed [DW-1:0]     d1_reg    [DIM];
    logic signed [ACC_W-1:0]  acc1_reg  [DIM];

    logic signed [DOT_W-1:0]  dot;
    logic signed [DOT_W-1:0]  e_ext;
    logic signed [DIST_W-1:0] dist_next;
    logic signed [DIST_W-1:0] dist_reg;
    logic signed [DW-1:0]     d2_reg    [DIM];
    logic signed [ACC_W-1:0]  acc2_reg  [DIM];

    logic signed [ACC_W-1:0]  term      [DIM];
    logic signed [ACC_W-1:0]  acc3_next [DIM];
    logic signed [ACC_W-1:0]  acc3_reg  [DIM];
    logic signed [DW-1:0]     d3_reg    [DIM];

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // Split the axis into signed components
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            u[k] = $signed(axis[k*FIELD_BITS +: FIELD_BITS]);
        end
    end

    // Stage 1: multiply each offset component by its axis component
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            prod_next[k] = PW'(d_in[k]) * PW'(u[k]);
        end
    end

    // Stage 2: sum the products and clamp to plus or minus the extent
    assign dot   = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
    assign e_ext = $signed(DOT_W'({extent, {AXIS_FRAC{1'b0}}}));

    always_comb
    begin
        if (dot > e_ext)
        begin
            dist_next = DIST_W'(e_ext);
        end
        else if (dot < -e_ext)
        begin
            dist_next = DIST_W'(-e_ext);
        end
        else
        begin
            dist_next = DIST_W'(dot);
        end
    end

    // Stage 3: scale the axis by the distance and add to the sum
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            term[k]      = ACC_W'(dist_reg) * ACC_W'(u[k]);
            acc3_next[k] = acc2_reg[k] + term[k];
        end
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        d1_reg   <= d_in;
        acc1_reg <= acc_in;
        dist_reg <= dist_next;
        d2_reg   <= d1_reg;
        acc2_reg <= acc1_reg;
        acc3_reg <= acc3_next;
        d3_reg   <= d2_reg;
    end

    assign out_valid = v3_reg;
    assign d_out     = d3_reg;
    assign acc_out   = acc3_reg;

    // The valid mark leaves only after passing v1_reg, v2_reg and v3_reg
    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> $past(in_valid, CELL_STAGES))
        else $error("cobb_cell: output valid without matching input");

    // The offset leaves unchanged alongside its valid mark (checked for x and z)
    a_offset_kept: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (d3_reg[0] == $past(d_in[0], CELL_STAGES)) &&
                   (d3_reg[2] == $past(d_in[2], CELL_STAGES)))
        else $error("cobb_cell: offset changed through the cell");

endmodule

`default_nettype wire

// ===== hw/rtl/cobb_round.sv =====
// ----------------------------------------------------------------------------
// cobb_round: output stage
// Rounds the sum to 8 fraction bits, half up, and saturates each coordinate
// to the signed coordinate range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobb_round #(
    parameter int W = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [cobb_pkg::ACC_W-1:0] acc [cobb_pkg::DIM],
    output logic                              done,
    output logic signed [W-1:0]               near [cobb_pkg::DIM]
);

    import cobb_pkg::*;

    localparam int RW = ACC_W - ROUND_SHIFT;
    localparam int SW = (W > RW) ? W : RW;

    localparam logic signed [ACC_W-1:0] HALF =
        $signed({{(ACC_W-ROUND_SHIFT){1'b0}}, 1'b1, {(ROUND_SHIFT-1){1'b0}}});
    localparam logic signed [SW-1:0] LIM_HI =
        $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] LIM_LO = ~LIM_HI;

    logic signed [ACC_W-1:0] biased  [DIM];
    logic signed [SW-1:0]    rounded [DIM];
    logic signed [W-1:0]     near_next [DIM];
    logic signed [W-1:0]     near_reg  [DIM];
    logic                    done_reg;

    // Round half up, then saturate
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            biased[k]  = acc[k] + HALF;
            rounded[k] = SW'($signed(biased[k][ACC_W-1:ROUND_SHIFT]));
            if (rounded[k] > LIM_HI)
            begin
                near_next[k] = W'(LIM_HI);
            end
            else if (rounded[k] < LIM_LO)
            begin
                near_next[k] = W'(LIM_LO);
            end
            else
            begin
                near_next[k] = W'(rounded[k]);
            end
        end
    end

    // Hold the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        near_reg <= near_next;
    end

    assign done = done_reg;
    assign near = near_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/closest_point_on_oriented_box_top.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_oriented_box_top: closest point on an oriented box
// Returns, for each query point, the nearest point on or inside a box set
// by center, three axes and three half extents.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle and returns one result per
// point, in order; each point passes the entry stage, three register
// stages in each of the three axis cells (multiply, sum and clamp, scale
// and add) and the rounding stage. busy is never raised, so start may
// stay high every cycle. Each result is shown for one cycle with done and
// cannot be held off by the receiver. Write the box registers only while
// no point is in flight.
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_oriented_box_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [cobb_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [cobb_pkg::CFG_WIDTH-1:0]           cfg_data,
    input  logic                                     start,
    output logic                                     busy,
    input  logic signed [COORD_WIDTH-1:0]            point_x,
    input  logic signed [COORD_WIDTH-1:0]            point_y,
    input  logic signed [COORD_WIDTH-1:0]            point_z,
    output logic                                     done,
    output logic signed [COORD_WIDTH-1:0]            near_x,
    output logic signed [COORD_WIDTH-1:0]            near_y,
    output logic signed [COORD_WIDTH-1:0]            near_z
);

    import cobb_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = ((W > FIELD_BITS) ? W : FIELD_BITS) + 1;

    logic [CFG_WIDTH-1:0] box_center_reg;
    logic [CFG_WIDTH-1:0] axis_first_reg;
    logic [CFG_WIDTH-1:0] axis_second_reg;
    logic [CFG_WIDTH-1:0] axis_third_reg;
    logic [CFG_WIDTH-1:0] half_extents_reg;

    logic [CFG_WIDTH-1:0] axes [AXIS_COUNT];

    logic signed [W-1:0]          pt [DIM];
    logic signed [FIELD_BITS-1:0] c  [DIM];
    logic signed [DW-1:0]         d0_next   [DIM];
    logic signed [ACC_W-1:0]      acc0_next [DIM];
    logic                         accept;

    logic                    chain_valid [AXIS_COUNT+1];
    logic signed [DW-1:0]    d_chain     [AXIS_COUNT+1][DIM];
    logic signed [ACC_W-1:0] acc_chain   [AXIS_COUNT+1][DIM];

    logic                    v0_reg;
    logic signed [DW-1:0]    d0_reg   [DIM];
    logic signed [ACC_W-1:0] acc0_reg [DIM];

    logic signed [W-1:0] near [DIM];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Register file: write on enable, ignore indexes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_center_reg   <= BOX_CENTER_RESET;
            axis_first_reg   <= AXIS_FIRST_RESET;
            axis_second_reg  <= AXIS_SECOND_RESET;
            axis_third_reg   <= AXIS_THIRD_RESET;
            half_extents_reg <= HALF_EXTENTS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOX_CENTER:   box_center_reg   <= cfg_data;
                REG_AXIS_FIRST:   axis_first_reg   <= cfg_data;
                REG_AXIS_SECOND:  axis_second_reg  <= cfg_data;
                REG_AXIS_THIRD:   axis_third_reg   <= cfg_data;
                REG_HALF_EXTENTS: half_extents_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign axes[0] = axis_first_reg;
    assign axes[1] = axis_second_reg;
    assign axes[2] = axis_third_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // Entry: offset from the center, sum seeded with the center
    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            c[k]         = $signed(box_center_reg[k*FIELD_BITS +: FIELD_BITS]);
            d0_next[k]   = DW'(pt[k]) - DW'(c[k]);
            acc0_next[k] = ACC_W'(c[k]) <<< ROUND_SHIFT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg   <= d0_next;
        acc0_reg <= acc0_next;
    end

    assign chain_valid[0] = v0_reg;
    assign d_chain[0]     = d0_reg;
    assign acc_chain[0]   = acc0_reg;

    // Row of axis cells
    for (genvar i = 0; i < AXIS_COUNT; i++)
    begin : g_cell
        cobb_cell #(
            .DW (DW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .d_in      (d_chain[i]),
            .acc_in    (acc_chain[i]),
            .axis      (axes[i]),
            .extent    (half_extents_reg[i*FIELD_BITS +: FIELD_BITS]),
            .out_valid (chain_valid[i+1]),
            .d_out     (d_chain[i+1]),
            .acc_out   (acc_chain[i+1])
        );
    end

    // Round and saturate
    cobb_round #(
        .W (W)
    ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[AXIS_COUNT]),
        .acc      (acc_chain[AXIS_COUNT]),
        .done     (done),
        .near     (near)
    );

    assign near_x = near[0];
    assign near_y = near[1];
    assign near_z = near[2];

    // Every result answers an earlier transfer, as set by LATENCY in the package
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("closest_point_on_oriented_box_top: result without transfer");

    // The offset arrives at the end of the row unchanged (checked for y)
    a_chain_offset: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[AXIS_COUNT] |->
            (d_chain[AXIS_COUNT][1] == $past(d_chain[0][1], CELL_STAGES * AXIS_COUNT)))
        else $error("closest_point_on_oriented_box_top: offset lost in the row");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: closest point on oriented box, self-checking testbench
// Streams query points through the block under a series of box settings,
// predicts each closest point in fixed point inside the bench and compares
// every returned coordinate against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cobb_pkg::*;

    localparam int     COORD_W     = 16;
    localparam longint NEAR_MAX    = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint NEAR_MIN    = -NEAR_MAX - 1;
    localparam int     CLK_HALF    = 10;
    localparam int     RESET_TICKS = 8;
    localparam int     PHASES      = 24;
    localparam int     CYCLE_LIMIT = 200000;

    localparam logic [CFG_INDEX_WIDTH-1:0] INDEX_TOP = '1;
    localparam logic [FIELD_BITS-1:0]      UNIT_POS  = 16'h4000;
    localparam logic [FIELD_BITS-1:0]      UNIT_NEG  = 16'hC000;
    // 1/sqrt(2) in Q2.14
    localparam logic [FIELD_BITS-1:0]      DIAG      = 16'd11585;

    // Three coordinates, x in element 0 (same layout as a box register)
    typedef logic [2:0][COORD_W-1:0] coord3_t;

    typedef enum logic [1:0] {
        ENTRY_POINT,
        ENTRY_WRITE,
        ENTRY_PAUSE
    } entry_kind_t;

    typedef struct {
        entry_kind_t                kind;
        coord3_t                    pt;
        int                         gap;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]       data;
    } entry_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_WIDTH-1:0]        cfg_data  = '0;
    logic                        start     = 1'b0;
    logic                        busy;
    logic signed [COORD_W-1:0]   point_x   = '0;
    logic signed [COORD_W-1:0]   point_y   = '0;
    logic signed [COORD_W-1:0]   point_z   = '0;
    logic                        done;
    logic signed [COORD_W-1:0]   near_x;
    logic signed [COORD_W-1:0]   near_y;
    logic signed [COORD_W-1:0]   near_z;

    entry_t                      pend_q [$];
    coord3_t                     near_q [$];
    logic [CFG_WIDTH-1:0]        box_reg [5];

    int                          taken_count   = 0;
    int                          checked_count = 0;
    int                          error_count   = 0;
    int                          limit_count   = 0;
    int                          gap_left      = 0;
    int                          cycle_count   = 0;
    int                          points_queued = 0;
    int                          writes_queued = 0;
    string                       axis_names    = "xyz";

    closest_point_on_oriented_box_top #(
        .COORD_WIDTH (COORD_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .done      (done),
        .near_x    (near_x),
        .near_y    (near_y),
        .near_z    (near_z)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [CFG_WIDTH-1:0] pack3(logic [FIELD_BITS-1:0] x,
                                                   logic [FIELD_BITS-1:0] y,
                                                   logic [FIELD_BITS-1:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [CFG_WIDTH-1:0] place(logic [FIELD_BITS-1:0] v, int k);
        return CFG_WIDTH'(v) << (k * FIELD_BITS);
    endfunction

    // Corner values favored, random otherwise
    function automatic logic [FIELD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_BITS-1:0] near_coord(logic [FIELD_BITS-1:0] c, int span);
        return c + FIELD_BITS'($urandom_range(0, 2 * span)) - FIELD_BITS'(span);
    endfunction

    // Idle burst after a point: none, sparse or frequent
    function automatic int pick_gap(int mode);
        if (mode == 1 && $urandom_range(0, 7) == 0)
            return $urandom_range(1, 17);
        if (mode == 2 && $urandom_range(0, 1) == 0)
            return $urandom_range(1, 17);
        return 0;
    endfunction

    function automatic longint field_s(logic [CFG_WIDTH-1:0] word, int k);
        logic signed [FIELD_BITS-1:0] f;
        f = word[k * FIELD_BITS +: FIELD_BITS];
        return f;
    endfunction

    task automatic queue_point(input logic [CFG_WIDTH-1:0] pt, input int gap);
        entry_t e;
        e.kind  = ENTRY_POINT;
        e.pt    = pt;
        e.gap   = gap;
        e.index = '0;
        e.data  = '0;
        pend_q.insert(pend_q.size(), e);
        points_queued++;
    endtask

    task automatic queue_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [CFG_WIDTH-1:0] val);
        entry_t e;
        e.kind  = ENTRY_WRITE;
        e.pt    = '0;
        e.gap   = 0;
        e.index = idx;
        e.data  = val;
        pend_q.insert(pend_q.size(), e);
        writes_queued++;
    endtask

    task automatic queue_pause();
        entry_t e;
        e.kind  = ENTRY_PAUSE;
        e.pt    = '0;
        e.gap   = 0;
        e.index = '0;
        e.data  = '0;
        pend_q.insert(pend_q.size(), e);
    endtask

    // ------------------------------------------------------------------
    // Closest point predictor: exact integer sums, one rounding and one
    // saturation per coordinate, from the mirrored box registers
    // ------------------------------------------------------------------
    function automatic coord3_t predict_near(coord3_t pt);
        longint                    ctr [3];
        longint                    ofs [3];
        longint                    acc [3];
        longint                    lim;
        longint                    proj;
        longint                    rnd;
        logic signed [COORD_W-1:0] pv;
        logic [CFG_WIDTH-1:0]      axis;
        coord3_t                   res;
        for (int k = 0; k < 3; k++)
        begin
            ctr[k] = field_s(box_reg[REG_BOX_CENTER], k);
            pv     = pt[k];
            ofs[k] = pv - ctr[k];
            acc[k] = ctr[k] <<< ROUND_SHIFT;
        end
        for (int i = 0; i < AXIS_COUNT; i++)
        begin
            axis = box_reg[int'(REG_AXIS_FIRST) + i];
            lim  = longint'(box_reg[REG_HALF_EXTENTS][i * FIELD_BITS +: FIELD_BITS]) <<< AXIS_FRAC;
            proj = 0;
            for (int k = 0; k < 3; k++)
                proj += ofs[k] * field_s(axis, k);
            if (proj > lim)
                proj = lim;
            if (proj < -lim)
                proj = -lim;
            for (int k = 0; k < 3; k++)
                acc[k] += proj * field_s(axis, k);
        end
        for (int k = 0; k < 3; k++)
        begin
            rnd = (acc[k] + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
            if (rnd > NEAR_MAX)
                rnd = NEAR_MAX;
            if (rnd < NEAR_MIN)
                rnd = NEAR_MIN;
            res[k] = rnd[COORD_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feed points and register writes from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        entry_t                     head;
        logic                       nxt_start;
        logic                       nxt_write;
        logic [CFG_INDEX_WIDTH-1:0] nxt_index;
        logic [CFG_WIDTH-1:0]       nxt_data;
        coord3_t                    nxt_pt;
        int                         nxt_gap;
        logic                       drained;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_write <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
            point_x   <= '0;
            point_y   <= '0;
            point_z   <= '0;
            gap_left  <= 0;
        end
        else
        begin
            nxt_start = start;
            nxt_write = 1'b0;
            nxt_index = cfg_index;
            nxt_data  = cfg_data;
            nxt_pt    = {point_z, point_y, point_x};
            nxt_gap   = gap_left;
            drained   = !start && (taken_count == checked_count);
            // hold the point while the block is busy
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    nxt_start = 1'b0;
                    nxt_gap   = gap_left - 1;
                end
                else if (pend_q.size() == 0)
                begin
                    nxt_start = 1'b0;
                end
                else
                begin
                    head      = pend_q[0];
                    nxt_start = 1'b0;
                    case (head.kind)
                        ENTRY_POINT:
                        begin
                            nxt_start = 1'b1;
                            nxt_pt    = head.pt;
                            nxt_gap   = head.gap;
                            void'(pend_q.pop_front());
                        end
                        ENTRY_WRITE:
                        begin
                            // write only once every point has come back
                            if (drained)
                            begin
                                nxt_write = 1'b1;
                                nxt_index = head.index;
                                nxt_data  = head.data;
                                void'(pend_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (drained)
                                void'(pend_q.pop_front());
                        end
                    endcase
                end
            end
            start     <= nxt_start;
            cfg_write <= nxt_write;
            cfg_index <= nxt_index;
            cfg_data  <= nxt_data;
            point_x   <= nxt_pt[0];
            point_y   <= nxt_pt[1];
            point_z   <= nxt_pt[2];
            gap_left  <= nxt_gap;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: mirror register writes, predict each point transfer and
    // check each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_proc
        coord3_t got;
        coord3_t want;
        if (!rst_n)
        begin
            taken_count                <= 0;
            checked_count              <= 0;
            box_reg[REG_BOX_CENTER]    <= BOX_CENTER_RESET;
            box_reg[REG_AXIS_FIRST]    <= AXIS_FIRST_RESET;
            box_reg[REG_AXIS_SECOND]   <= AXIS_SECOND_RESET;
            box_reg[REG_AXIS_THIRD]    <= AXIS_THIRD_RESET;
            box_reg[REG_HALF_EXTENTS]  <= HALF_EXTENTS_RESET;
        end
        else
        begin
            // compare a result against the oldest prediction
            if (done)
            begin
                got = {near_z, near_y, near_x};
                if (near_q.size() == 0)
                begin
                    $display("%0t: unexpected result (%0d, %0d, %0d)",
                             $time, near_x, near_y, near_z);
                    error_count++;
                end
                else
                begin
                    want = near_q.pop_front();
                    for (int k = 0; k < 3; k++)
                    begin
                        if (got[k] !== want[k])
                        begin
                            $display("%0t: near_%c expected %0d actual %0d", $time,
                                     axis_names[k], $signed(want[k]), $signed(got[k]));
                            error_count++;
                        end
                        if ($signed(want[k]) == NEAR_MAX || $signed(want[k]) == NEAR_MIN)
                            limit_count++;
                    end
                    checked_count <= checked_count + 1;
                end
            end
            // predict from the box in force at this transfer
            if (start && !busy)
            begin
                near_q.insert(near_q.size(), predict_near({point_z, point_y, point_x}));
                taken_count <= taken_count + 1;
            end
            // writes past the register list are dropped
            if (cfg_write && cfg_index <= REG_HALF_EXTENTS)
                box_reg[cfg_index] <= cfg_data;
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d results checked",
                     cycle_count, checked_count, points_queued);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                    gap_mode;
        int                    n_points;
        int                    s;
        int                    sel;
        int                    span;
        logic [FIELD_BITS-1:0] cx;
        logic [FIELD_BITS-1:0] cy;
        logic [FIELD_BITS-1:0] cz;
        logic [CFG_WIDTH-1:0]  ext;

        // reset box: center at the origin, zero extents
        queue_point(pack3(16'h7FFF, 16'h8000, 16'h1234), 0);
        queue_point(pack3(16'h8000, 16'h7FFF, 16'h0000), 0);

        // axis-aligned box off the origin, one extent near its top
        queue_write(REG_BOX_CENTER, pack3(16'h0100, 16'hFE00, 16'h0080));
        queue_write(REG_AXIS_FIRST, place(UNIT_POS, 0));
        queue_write(REG_AXIS_SECOND, place(UNIT_POS, 1));
        queue_write(REG_AXIS_THIRD, place(UNIT_POS, 2));
        queue_write(REG_HALF_EXTENTS, pack3(16'h0200, 16'h0100, 16'h7FFF));
        queue_write(INDEX_TOP, '1);
        queue_point(pack3(16'h0000, 16'h0000, 16'h0000), 0);
        queue_point(pack3(16'h0100, 16'hFE00, 16'h0080), 0);
        queue_point(pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
        queue_point(pack3(16'h8000, 16'h8000, 16'h8000), 3);
        queue_point(pack3(16'h0180, 16'hFE80, 16'h8000), 0);
        queue_point(pack3(16'h0000, 16'h0000, 16'h7FFF), 0);
        queue_pause();

        // extents past 32767 taken as magnitudes, axes turned 45 degrees
        queue_write(REG_HALF_EXTENTS, '1);
        queue_write(REG_AXIS_FIRST, place(DIAG, 0) | place(DIAG, 1));
        queue_write(REG_AXIS_SECOND, place(-DIAG, 0) | place(DIAG, 1));
        queue_write(REG_AXIS_THIRD, place(UNIT_NEG, 2));
        queue_point(pack3(16'h7FFF, 16'h8000, 16'h7FFF), 0);
        queue_point(pack3(16'h8000, 16'h7FFF, 16'h8000), 0);
        queue_point(pack3(16'h1234, 16'hEDCB, 16'h0001), 0);
        queue_point(pack3(16'hFFFF, 16'hFFFF, 16'hFFFF), 0);

        // long skewed axes push the sum beyond the coordinate range
        queue_write(REG_BOX_CENTER, pack3(16'h7FFF, 16'h8000, 16'h7FFF));
        queue_write(REG_AXIS_FIRST, pack3(16'h7FFF, 16'h7FFF, 16'h7FFF));
        queue_write(REG_AXIS_SECOND, pack3(16'h8000, 16'h8000, 16'h8000));
        queue_write(REG_AXIS_THIRD, pack3(16'h7FFF, 16'h8000, 16'h0000));
        queue_point(pack3(16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
        queue_point(pack3(16'h8000, 16'h8000, 16'h8000), 0);
        queue_point(pack3(16'h7FFF, 16'h8000, 16'h0000), 0);
        queue_point(pack3(16'h0000, 16'h0000, 16'h0000), 0);

        // every register all ones
        queue_write(REG_BOX_CENTER, '1);
        queue_write(REG_AXIS_FIRST, '1);
        queue_write(REG_AXIS_SECOND, '1);
        queue_write(REG_AXIS_THIRD, '1);
        queue_write(REG_HALF_EXTENTS, '1);
        queue_point(pack3(16'h7FFF, 16'h0000, 16'h8000), 0);
        queue_point(pack3(16'h8000, 16'hFFFF, 16'h7FFF), 0);
        cx = 16'hFFFF;
        cy = 16'hFFFF;
        cz = 16'hFFFF;

        // random boxes, each followed by a burst of points
        for (int p = 0; p < PHASES; p++)
        begin
            gap_mode = (p == PHASES - 1) ? 0 : $urandom_range(0, 2);
            n_points = (p == PHASES - 1) ? 160 : $urandom_range(50, 90);

            // center near the origin, anywhere, or kept
            sel = $urandom_range(0, 3);
            if (sel == 0)
            begin
                cx = FIELD_BITS'($urandom_range(0, 16'h1000)) - 16'h0800;
                cy = FIELD_BITS'($urandom_range(0, 16'h1000)) - 16'h0800;
                cz = FIELD_BITS'($urandom_range(0, 16'h1000)) - 16'h0800;
            end
            else if (sel != 3)
            begin
                cx = pick_coord();
                cy = pick_coord();
                cz = pick_coord();
            end
            if (sel != 3)
                queue_write(REG_BOX_CENTER, pack3(cx, cy, cz));

            // axes: signed permutation, 45 degree turn, or arbitrary
            sel = $urandom_range(0, 2);
            s   = $urandom_range(0, 2);
            case (sel)
                0:
                begin
                    for (int i = 0; i < AXIS_COUNT; i++)
                        queue_write(CFG_INDEX_WIDTH'(int'(REG_AXIS_FIRST) + i),
                                    place($urandom_range(0, 1) ? UNIT_POS : UNIT_NEG,
                                          (i + s) % 3));
                end
                1:
                begin
                    queue_write(REG_AXIS_FIRST, place(DIAG, s) | place(DIAG, (s + 1) % 3));
                    queue_write(REG_AXIS_SECOND, place(-DIAG, s) | place(DIAG, (s + 1) % 3));
                    queue_write(REG_AXIS_THIRD, place(UNIT_POS, (s + 2) % 3));
                end
                default:
                begin
                    for (int i = 0; i < AXIS_COUNT; i++)
                        queue_write(CFG_INDEX_WIDTH'(int'(REG_AXIS_FIRST) + i),
                                    pack3(pick_coord(), pick_coord(), pick_coord()));
                end
            endcase

            // extents: small, below 32768, any, zero, or all ones
            case ($urandom_range(0, 4))
                0: ext = pack3(FIELD_BITS'($urandom_range(0, 16'h0800)),
                               FIELD_BITS'($urandom_range(0, 16'h0800)),
                               FIELD_BITS'($urandom_range(0, 16'h0800)));
                1: ext = pack3(FIELD_BITS'($urandom_range(0, 16'h7FFF)),
                               FIELD_BITS'($urandom_range(0, 16'h7FFF)),
                               FIELD_BITS'($urandom_range(0, 16'h7FFF)));
                2: ext = CFG_WIDTH'({$urandom, $urandom});
                3: ext = '0;
                default: ext = '1;
            endcase
            queue_write(REG_HALF_EXTENTS, ext);

            if ($urandom_range(0, 3) == 0)
                queue_write(CFG_INDEX_WIDTH'($urandom_range(int'(REG_HALF_EXTENTS) + 1,
                                                             int'(INDEX_TOP))),
                            CFG_WIDTH'({$urandom, $urandom}));

            // points: half around the center, the rest anywhere or at corners
            span = $urandom_range(1, 16'h0C00);
            for (int n = 0; n < n_points; n++)
            begin
                if (p != PHASES - 1 && n == n_points / 2 && $urandom_range(0, 2) == 0)
                    queue_pause();
                sel = $urandom_range(0, 3);
                if (sel < 2)
                    queue_point(pack3(near_coord(cx, span), near_coord(cy, span),
                                      near_coord(cz, span)), pick_gap(gap_mode));
                else if (sel == 2)
                    queue_point(CFG_WIDTH'({$urandom, $urandom}), pick_gap(gap_mode));
                else
                    queue_point(pack3(pick_coord(), pick_coord(), pick_coord()),
                                pick_gap(gap_mode));
            end
        end

        // release reset, then wait for every point to come back
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        while (taken_count != points_queued || checked_count != taken_count)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (near_q.size() != 0)
        begin
            $display("%0t: %0d predictions never matched by a result", $time, near_q.size());
            error_count++;
        end

        $display("Covered %0d points over %0d box settings and %0d register writes,",
                 taken_count, PHASES + 5, writes_queued);
        $display("with %0d coordinates at the range limits and %0d mismatches.",
                 limit_count, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
